@@ hdl/rsrs_pkg.sv @@
package rsrs_pkg;

  // Fixed field widths.
  localparam int unsigned LABEL_W    = 10;
  localparam int unsigned MIN_W      = 24;
  localparam int unsigned MAXSEL_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_REGION_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SELECTED    = 2'd1;

  // Configuration reset values.
  localparam logic [MIN_W-1:0]    MIN_SIZE_RST = 24'd1;
  localparam logic [MAXSEL_W-1:0] MAX_SEL_RST  = 4'd8;

  // Commands from the controller to the histogram datapath.
  typedef struct packed {
    logic pix_acc;   // a pixel is accepted this cycle
    logic zero_wr;   // write zero at the sweep address
    logic scan_rd;   // read the sweep address for ranking
    logic clr_high;  // clear the highest label
  } dp_cmd_t;

  // Commands from the controller to the ranking row.
  typedef struct packed {
    logic clr;       // drop all ranked entries
    logic emit;      // present the head entry and shift the row up
  } topk_cmd_t;

  // Status from the ranking row.
  typedef struct packed {
    logic head_valid;
    logic next_valid;
  } topk_stat_t;

endpackage

@@ hdl/region_size_rank_select_top.sv @@
// Channel  | Direction | Handshake                     | Payload
// -------- | --------- | ----------------------------- | -------------------------------
// pixel    | in        | start high, busy low          | label_i, last_i
// result   | out       | result_strobe_o, one cycle    | region_o, region_size_o,
//          |           |                               | found_o, last_result_o
// config   | in        | cfg_valid_i and cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Pixels stream at one item per cycle while busy is low; the histogram
// read-modify-write forwards the previous write so back-to-back pixels on one
// label count correctly. After the final pixel, busy stays high through a
// flush, a sweep that reads each label up to the highest label seen (and clears
// it), settling states that rank the last entry, and the emission of the results.
// After reset the histogram memory is cleared one entry at a time with busy
// high; configuration writes are taken at any time.
// Results cannot be stalled: each is presented for exactly one cycle.
module region_size_rank_select_top #(
  parameter int unsigned MAX_REGIONS = 1024,
  parameter int unsigned MAX_SELECT  = 8,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rsrs_pkg::LABEL_W-1:0]      label_i,
  input  logic                              last_i,
  output logic                              result_strobe_o,
  output logic [rsrs_pkg::LABEL_W-1:0]      region_o,
  output logic [COUNT_BITS-1:0]             region_size_o,
  output logic                              found_o,
  output logic                              last_result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsrs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rsrs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_REGIONS);
  localparam int unsigned SW = $clog2(MAX_SELECT + 1);

  logic [rsrs_pkg::MIN_W-1:0]    min_size_q;
  logic [rsrs_pkg::MAXSEL_W-1:0] max_sel_q;
  logic [SW-1:0]                 limit;

  rsrs_pkg::dp_cmd_t    dp_cmd;
  rsrs_pkg::topk_cmd_t  topk_cmd;
  rsrs_pkg::topk_stat_t topk_stat;
  logic [AW-1:0]        addr;
  logic                 scan_end;
  logic                 cand_valid;
  logic [COUNT_BITS-1:0] cand_size;
  logic [AW-1:0]        cand_lab;
  logic [AW-1:0]        res_lab;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= rsrs_pkg::MIN_SIZE_RST;
      max_sel_q  <= rsrs_pkg::MAX_SEL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == rsrs_pkg::REG_MIN_REGION_SIZE) begin
        min_size_q <= cfg_data_i[rsrs_pkg::MIN_W-1:0];
      end else if (cfg_index_i == rsrs_pkg::REG_MAX_SELECTED) begin
        max_sel_q <= cfg_data_i[rsrs_pkg::MAXSEL_W-1:0];
      end
    end
  end

  // Results per frame: zero means one, and the row depth caps it.
  always_comb begin
    priority if (max_sel_q == '0) begin
      limit = SW'(1);
    end else if (32'(max_sel_q) > MAX_SELECT) begin
      limit = SW'(MAX_SELECT);
    end else begin
      limit = SW'(max_sel_q);
    end
  end

  rsrs_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .AW          (AW),
    .SW          (SW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_i      (last_i),
    .busy        (busy),
    .limit_i     (limit),
    .scan_end_i  (scan_end),
    .topk_stat_i (topk_stat),
    .dp_cmd_o    (dp_cmd),
    .topk_cmd_o  (topk_cmd),
    .addr_o      (addr),
    .strobe_o    (result_strobe_o),
    .last_o      (last_result_o)
  );

  rsrs_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .COUNT_BITS  (COUNT_BITS),
    .AW          (AW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .addr_i       (addr),
    .label_i      (label_i),
    .min_size_i   (min_size_q),
    .scan_end_o   (scan_end),
    .cand_valid_o (cand_valid),
    .cand_size_o  (cand_size),
    .cand_lab_o   (cand_lab)
  );

  rsrs_topk #(
    .MAX_SELECT (MAX_SELECT),
    .COUNT_BITS (COUNT_BITS),
    .AW         (AW)
  ) u_topk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (topk_cmd),
    .cand_valid_i (cand_valid),
    .cand_size_i  (cand_size),
    .cand_lab_i   (cand_lab),
    .stat_o       (topk_stat),
    .res_lab_o    (res_lab),
    .res_size_o   (region_size_o),
    .res_found_o  (found_o)
  );

  assign region_o = rsrs_pkg::LABEL_W'(res_lab);

endmodule

@@ hdl/rsrs_dp.sv @@
module rsrs_dp #(
  parameter int unsigned MAX_REGIONS = 1024,
  parameter int unsigned COUNT_BITS  = 24,
  parameter int unsigned AW          = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rsrs_pkg::dp_cmd_t            cmd_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [rsrs_pkg::LABEL_W-1:0] label_i,
  input  logic [rsrs_pkg::MIN_W-1:0]   min_size_i,
  output logic                         scan_end_o,
  output logic                         cand_valid_o,
  output logic [COUNT_BITS-1:0]        cand_size_o,
  output logic [AW-1:0]                cand_lab_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] hist_q [MAX_REGIONS];
  logic [COUNT_BITS-1:0] rdata_q;

  logic                  in_range;
  logic [AW-1:0]         pix_addr;
  logic [AW-1:0]         rd_addr;

  logic                  s1_valid_q;
  logic [AW-1:0]         s1_addr_q;
  logic                  w_valid_q;
  logic [AW-1:0]         w_addr_q;
  logic [COUNT_BITS-1:0] w_data_q;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] inc;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic [AW-1:0]         high_q;
  logic                  scan_rd_q;
  logic [AW-1:0]         scan_lab_q;
  logic                  cand_valid_q;
  logic [COUNT_BITS-1:0] cand_size_q;
  logic [AW-1:0]         cand_lab_q;

  // Labels at or above the histogram depth are not counted.
  assign in_range = 32'(label_i) < MAX_REGIONS;
  assign pix_addr = AW'(label_i);
  assign rd_addr  = cmd_i.scan_rd ? addr_i : pix_addr;

  // Forward the write of the previous pixel when it hit the same entry.
  assign base = (w_valid_q && (w_addr_q == s1_addr_q)) ? w_data_q : rdata_q;
  assign inc  = (base == CountMax) ? base : base + 1'b1;

  // Sweep writes clear entries; otherwise the pixel update is written back.
  assign wr_en   = cmd_i.zero_wr || s1_valid_q;
  assign wr_addr = cmd_i.zero_wr ? addr_i : s1_addr_q;
  assign wr_data = cmd_i.zero_wr ? '0 : inc;

  assign scan_end_o = (addr_i == high_q);

  // Histogram memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_q[wr_addr] <= wr_data;
    end
    rdata_q <= hist_q[rd_addr];
  end

  // Pipeline control and the highest label seen in the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      w_valid_q    <= 1'b0;
      scan_rd_q    <= 1'b0;
      cand_valid_q <= 1'b0;
      high_q       <= '0;
    end else begin
      s1_valid_q   <= cmd_i.pix_acc && in_range;
      w_valid_q    <= s1_valid_q;
      scan_rd_q    <= cmd_i.scan_rd;
      cand_valid_q <= scan_rd_q && (32'(rdata_q) >= 32'(min_size_i));
      if (cmd_i.clr_high) begin
        high_q <= '0;
      end else if (cmd_i.pix_acc && in_range && (pix_addr > high_q)) begin
        high_q <= pix_addr;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_addr_q   <= pix_addr;
    w_addr_q    <= s1_addr_q;
    w_data_q    <= inc;
    scan_lab_q  <= addr_i;
    cand_size_q <= rdata_q;
    cand_lab_q  <= scan_lab_q;
  end

  assign cand_valid_o = cand_valid_q;
  assign cand_size_o  = cand_size_q;
  assign cand_lab_o   = cand_lab_q;

  // A pixel write-back never coincides with a sweep write.
  a_no_wr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && cmd_i.zero_wr))
    else $error("pixel write-back collides with a sweep write");

endmodule

@@ hdl/rsrs_topk.sv @@
module rsrs_topk #(
  parameter int unsigned MAX_SELECT = 8,
  parameter int unsigned COUNT_BITS = 24,
  parameter int unsigned AW         = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rsrs_pkg::topk_cmd_t    cmd_i,
  input  logic                   cand_valid_i,
  input  logic [COUNT_BITS-1:0]  cand_size_i,
  input  logic [AW-1:0]          cand_lab_i,
  output rsrs_pkg::topk_stat_t   stat_o,
  output logic [AW-1:0]          res_lab_o,
  output logic [COUNT_BITS-1:0]  res_size_o,
  output logic                   res_found_o
);

  logic [MAX_SELECT-1:0] valid_q, valid_d;
  logic [COUNT_BITS-1:0] size_q [MAX_SELECT];
  logic [COUNT_BITS-1:0] size_d [MAX_SELECT];
  logic [AW-1:0]         lab_q  [MAX_SELECT];
  logic [AW-1:0]         lab_d  [MAX_SELECT];
  logic [MAX_SELECT-1:0] ahead;
  logic [MAX_SELECT-1:0] ahead_sh;
  logic [MAX_SELECT:0]   valid_ext;

  logic [AW-1:0]         res_lab_q;
  logic [COUNT_BITS-1:0] res_size_q;
  logic                  res_found_q;

  // Each cell decides whether the candidate ranks ahead of its entry.
  always_comb begin
    for (int k = 0; k < MAX_SELECT; k++) begin
      ahead[k] = !valid_q[k] || (cand_size_i > size_q[k]) ||
                 ((cand_size_i == size_q[k]) && (cand_lab_i > lab_q[k]));
    end
  end

  assign ahead_sh = ahead << 1;

  // Row update: clear, shift up for output, or insert in rank order.
  always_comb begin
    valid_d = valid_q;
    size_d  = size_q;
    lab_d   = lab_q;
    priority if (cmd_i.clr) begin
      valid_d = '0;
    end else if (cmd_i.emit) begin
      for (int k = 0; k < MAX_SELECT - 1; k++) begin
        valid_d[k] = valid_q[k+1];
        size_d[k]  = size_q[k+1];
        lab_d[k]   = lab_q[k+1];
      end
      valid_d[MAX_SELECT-1] = 1'b0;
    end else if (cand_valid_i) begin
      for (int k = 0; k < MAX_SELECT; k++) begin
        if (ahead[k] && !ahead_sh[k]) begin
          valid_d[k] = 1'b1;
          size_d[k]  = cand_size_i;
          lab_d[k]   = cand_lab_i;
        end
      end
      for (int k = 1; k < MAX_SELECT; k++) begin
        if (ahead_sh[k]) begin
          valid_d[k] = valid_q[k-1];
          size_d[k]  = size_q[k-1];
          lab_d[k]   = lab_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Cell payload and the result registers.
  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    lab_q  <= lab_d;
    if (cmd_i.emit) begin
      res_found_q <= valid_q[0];
      res_size_q  <= valid_q[0] ? size_q[0] : '0;
      res_lab_q   <= valid_q[0] ? lab_q[0] : '0;
    end
  end

  assign valid_ext         = {1'b0, valid_q};
  assign stat_o.head_valid = valid_q[0];
  assign stat_o.next_valid = valid_ext[1];
  assign res_lab_o         = res_lab_q;
  assign res_size_o        = res_size_q;
  assign res_found_o       = res_found_q;

  // Occupied cells always form an unbroken run from the head.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q & (valid_q + 1'b1)) == '0)
    else $error("ranking row has a gap");

  // Emitting from an empty head leaves the row empty.
  a_empty_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !cmd_i.clr && !valid_q[0]) |=> (valid_q == '0))
    else $error("row not empty after emitting an empty head");

endmodule

@@ hdl/rsrs_ctrl.sv @@
module rsrs_ctrl #(
  parameter int unsigned MAX_REGIONS = 1024,
  parameter int unsigned AW          = 10,
  parameter int unsigned SW          = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 last_i,
  output logic                 busy,
  input  logic [SW-1:0]        limit_i,
  input  logic                 scan_end_i,
  input  rsrs_pkg::topk_stat_t topk_stat_i,
  output rsrs_pkg::dp_cmd_t    dp_cmd_o,
  output rsrs_pkg::topk_cmd_t  topk_cmd_o,
  output logic [AW-1:0]        addr_o,
  output logic                 strobe_o,
  output logic                 last_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_RUN,
    ST_FLUSH,
    ST_SCAN,
    ST_SETTLE_RD,
    ST_SETTLE_CAND,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic          strobe_q, strobe_d;
  logic          last_q, last_d;
  logic          fin;

  assign busy = (state_q != ST_RUN);

  // The current result closes the frame when nothing more may follow it.
  assign fin = !topk_stat_i.head_valid || !topk_stat_i.next_valid ||
               (SW'(cnt_q + 1'b1) == limit_i);

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    strobe_d   = 1'b0;
    last_d     = last_q;
    dp_cmd_o   = '0;
    topk_cmd_o = '0;
    unique case (state_q)
      ST_INIT: begin
        dp_cmd_o.zero_wr = 1'b1;
        if (idx_q == AW'(MAX_REGIONS - 1)) begin
          idx_d   = '0;
          state_d = ST_RUN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RUN: begin
        if (start) begin
          dp_cmd_o.pix_acc = 1'b1;
          if (last_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        topk_cmd_o.clr = 1'b1;
        idx_d          = '0;
        state_d        = ST_SCAN;
      end
      ST_SCAN: begin
        dp_cmd_o.scan_rd = 1'b1;
        dp_cmd_o.zero_wr = 1'b1;
        if (scan_end_i) begin
          state_d = ST_SETTLE_RD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SETTLE_RD: begin
        dp_cmd_o.clr_high = 1'b1;
        state_d           = ST_SETTLE_CAND;
      end
      ST_SETTLE_CAND: begin
        cnt_d   = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        topk_cmd_o.emit = 1'b1;
        strobe_d        = 1'b1;
        last_d          = fin;
        if (fin) begin
          state_d = ST_RUN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_INIT;
        idx_d   = '0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      idx_q    <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  assign addr_o   = idx_q;
  assign strobe_o = strobe_q;
  assign last_o   = last_q;

  // A result strobe is only raised by the emit state.
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q == ST_EMIT))
    else $error("result strobe without an emit cycle");

  // An accepted final pixel starts the frame wrap-up.
  a_last_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> (state_q == ST_FLUSH))
    else $error("final pixel did not start the wrap-up");

endmodule

@@ tb/region_rank_checker.sv @@
`timescale 1ns / 1ps

module region_rank_checker
  import rsrs_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 1024,
  parameter int unsigned MAX_SELECT  = 8,
  parameter int unsigned COUNT_BITS  = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [LABEL_W-1:0]    label_i,
  input  logic                  last_i,
  input  logic                  result_strobe_i,
  input  logic [LABEL_W-1:0]    region_i,
  input  logic [COUNT_BITS-1:0] region_size_i,
  input  logic                  found_i,
  input  logic                  last_result_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o,
  output int unsigned           pixels_o,
  output int unsigned           frames_o,
  output int unsigned           results_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [LABEL_W-1:0]    region;
    logic [COUNT_BITS-1:0] size;
    logic                  found;
    logic                  last_res;
  } region_result_t;

  // Local copy of the block's histogram, highest label and registers.
  logic [COUNT_BITS-1:0] pixel_count [MAX_REGIONS];
  logic [LABEL_W-1:0]    top_label;
  logic [MIN_W-1:0]      min_size;
  logic [MAXSEL_W-1:0]   max_sel;

  region_result_t expected_regions [$];

  // Appends one expected result at the tail of the queue.
  task automatic add_expected(input region_result_t res);
    expected_regions = {expected_regions, res};
  endtask

  // Picks the largest qualifying regions one by one, ties going to the higher
  // label, then clears the histogram for the next frame.
  task automatic rank_regions();
    int unsigned    quota;
    int unsigned    picked;
    int unsigned    best;
    logic [COUNT_BITS-1:0] best_cnt;
    bit             have;
    bit             chosen [MAX_REGIONS];
    region_result_t res;
    quota = (max_sel == 0) ? 1 : ((max_sel > MAX_SELECT) ? MAX_SELECT : max_sel);
    foreach (chosen[i]) chosen[i] = 1'b0;
    picked   = 0;
    best     = 0;
    best_cnt = '0;
    while (picked < quota) begin
      have = 1'b0;
      for (int unsigned lbl = 0; lbl <= top_label && lbl < MAX_REGIONS; lbl++) begin
        if (!chosen[lbl] && pixel_count[lbl] >= min_size &&
            (!have || pixel_count[lbl] > best_cnt ||
             (pixel_count[lbl] == best_cnt && lbl > best))) begin
          have     = 1'b1;
          best     = lbl;
          best_cnt = pixel_count[lbl];
        end
      end
      if (!have) break;
      chosen[best] = 1'b1;
      res.region   = best[LABEL_W-1:0];
      res.size     = best_cnt;
      res.found    = 1'b1;
      res.last_res = 1'b0;
      add_expected(res);
      picked++;
    end
    // An empty selection still produces one closing result.
    if (picked == 0) begin
      res = '0;
      res.last_res = 1'b1;
      add_expected(res);
    end else begin
      res = expected_regions.pop_back();
      res.last_res = 1'b1;
      add_expected(res);
    end
    foreach (pixel_count[i]) pixel_count[i] = '0;
    top_label = '0;
  endtask

  // Watch all three channels on the rising edge; results first, since they
  // always belong to a frame that closed earlier.
  always @(posedge clk_i or negedge rst_ni) begin
    region_result_t want;
    if (!rst_ni) begin
      foreach (pixel_count[i]) pixel_count[i] = '0;
      top_label = '0;
      min_size  = MIN_SIZE_RST;
      max_sel   = MAX_SEL_RST;
      expected_regions.delete();
      pending_o = 0;
      errors_o  = 0;
      pixels_o  = 0;
      frames_o  = 0;
      results_o = 0;
    end else begin
      // Compare a presented result with the oldest expectation.
      if (result_strobe_i) begin
        results_o++;
        if (expected_regions.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result: expected none, actual region %0d size %0d",
                   $time, region_i, region_size_i);
          $display("%0t:   found %0b last %0b", $time, found_i, last_result_i);
        end else begin
          want = expected_regions.pop_front();
          if (region_i !== want.region) begin
            errors_o++;
            $display("%0t: region expected %0d actual %0d", $time, want.region, region_i);
          end
          if (region_size_i !== want.size) begin
            errors_o++;
            $display("%0t: region_size expected %0d actual %0d",
                     $time, want.size, region_size_i);
          end
          if (found_i !== want.found) begin
            errors_o++;
            $display("%0t: found expected %0b actual %0b", $time, want.found, found_i);
          end
          if (last_result_i !== want.last_res) begin
            errors_o++;
            $display("%0t: last_result expected %0b actual %0b",
                     $time, want.last_res, last_result_i);
          end
        end
      end

      // Register writes.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MIN_REGION_SIZE: min_size = cfg_data_i[MIN_W-1:0];
          REG_MAX_SELECTED:    max_sel  = cfg_data_i[MAXSEL_W-1:0];
          default: ;
        endcase
      end

      // Count an accepted pixel; a last pixel closes the frame after counting.
      if (start_i && !busy_i) begin
        pixels_o++;
        if (label_i < MAX_REGIONS) begin
          if (pixel_count[label_i] != COUNT_MAX)
            pixel_count[label_i] = pixel_count[label_i] + 1'b1;
          if (label_i > top_label) top_label = label_i;
        end
        if (last_i) begin
          frames_o++;
          rank_regions();
        end
      end
      pending_o = expected_regions.size();
    end
  end

endmodule

@@ tb/tb_region_size_rank_select_top.sv @@
`timescale 1ns / 1ps

module tb_region_size_rank_select_top;
  import rsrs_pkg::*;

  localparam int unsigned MAX_REGIONS = 1024;
  localparam int unsigned MAX_SELECT  = 8;
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned PHASE_ITEMS = 100;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start  = 1'b0;
  logic                  busy;
  logic [LABEL_W-1:0]    label_i = '0;
  logic                  last_i  = 1'b0;
  logic                  result_strobe_o;
  logic [LABEL_W-1:0]    region_o;
  logic [COUNT_BITS-1:0] region_size_o;
  logic                  found_o;
  logic                  last_result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned pixels;
  int unsigned frames;
  int unsigned results;
  int unsigned items_sent = 0;
  int unsigned gap_pct = 0;
  int unsigned cycle_count = 0;

  region_size_rank_select_top #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_SELECT  (MAX_SELECT),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .label_i         (label_i),
    .last_i          (last_i),
    .result_strobe_o (result_strobe_o),
    .region_o        (region_o),
    .region_size_o   (region_size_o),
    .found_o         (found_o),
    .last_result_o   (last_result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  region_rank_checker #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_SELECT  (MAX_SELECT),
    .COUNT_BITS  (COUNT_BITS)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .label_i         (label_i),
    .last_i          (last_i),
    .result_strobe_i (result_strobe_o),
    .region_i        (region_o),
    .region_size_i   (region_size_o),
    .found_i         (found_o),
    .last_result_i   (last_result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending),
    .errors_o        (errors),
    .pixels_o        (pixels),
    .frames_o        (frames),
    .results_o       (results)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one pixel, possibly after some idle cycles, and return on the edge
  // that accepts it.
  task automatic send_pixel(input logic [LABEL_W-1:0] lab, input logic lst);
    if ($urandom_range(99) < gap_pct) begin
      start   <= 1'b0;
      label_i <= LABEL_W'($urandom);
      last_i  <= 1'($urandom);
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    start   <= 1'b1;
    label_i <= lab;
    last_i  <= lst;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
  endtask

  // One frame of random labels drawn from 0..span.
  task automatic send_frame(input int unsigned len, input int unsigned span);
    for (int unsigned n = 1; n <= len; n++)
      send_pixel(LABEL_W'($urandom_range(span)), n == len);
  endtask

  // Stop sending, wait for every outstanding result and let the block settle.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random settings, mostly low thresholds so that regions qualify.
  task automatic pick_settings();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5)      write_reg(REG_MIN_REGION_SIZE, CFG_DATA_W'($urandom_range(3)));
    else if (pick < 8) write_reg(REG_MIN_REGION_SIZE, CFG_DATA_W'($urandom_range(8, 1)));
    else if (pick < 9) write_reg(REG_MIN_REGION_SIZE, CFG_DATA_W'($urandom));
    else               write_reg(REG_MIN_REGION_SIZE, {CFG_DATA_W{1'b1}});
    write_reg(REG_MAX_SELECTED, CFG_DATA_W'($urandom_range(15)));
  endtask

  initial begin
    int unsigned phase_base;
    int unsigned span_pick;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: single pixel, extreme labels with a size tie, a zero
    // threshold with an oversized limit, nothing qualifying with a zero limit,
    // a limit of one, and more qualifying regions than the limit allows.
    write_reg(REG_MIN_REGION_SIZE, 24'd1);
    write_reg(REG_MAX_SELECTED, 24'd8);
    send_pixel(10'd0, 1'b1);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd1023, 1'b0);
    send_pixel(10'd5, 1'b0);
    send_pixel(10'd5, 1'b0);
    send_pixel(10'd512, 1'b1);
    drain_results();
    write_reg(REG_MIN_REGION_SIZE, 24'd0);
    write_reg(REG_MAX_SELECTED, 24'd15);
    send_pixel(10'd3, 1'b0);
    send_pixel(10'd7, 1'b1);
    drain_results();
    write_reg(REG_MIN_REGION_SIZE, 24'hFFFFFF);
    write_reg(REG_MAX_SELECTED, 24'd0);
    send_frame(3, 0);
    drain_results();
    write_reg(REG_MIN_REGION_SIZE, 24'd2);
    write_reg(REG_MAX_SELECTED, 24'd1);
    send_pixel(10'd9, 1'b0);
    send_pixel(10'd9, 1'b0);
    send_pixel(10'd4, 1'b0);
    send_pixel(10'd4, 1'b0);
    send_pixel(10'd4, 1'b1);
    drain_results();
    write_reg(REG_MIN_REGION_SIZE, 24'd1);
    write_reg(REG_MAX_SELECTED, 24'd8);
    for (int unsigned lbl = 20; lbl <= 28; lbl++)
      send_pixel(lbl[LABEL_W-1:0], lbl == 28);

    // Random frames in three phases of sender gaps; settings sometimes change between frames.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct    = (phase == 0) ? 25 : ((phase == 1) ? 55 : 0);
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          drain_results();
          pick_settings();
        end
        span_pick = $urandom_range(9);
        if (span_pick < 7)      send_frame($urandom_range(16, 1), 15);
        else if (span_pick < 9) send_frame($urandom_range(40, 1), 127);
        else                    send_frame($urandom_range(16, 1), 1023);
      end
    end

    // Wait out the last frame, then allow time for any stray result.
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("Checked %0d results from %0d frames (%0d pixels), under varied thresholds",
             results, frames, pixels);
    $display("and limits, with sender gaps of 25%%, 55%% and none.");
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rsrs_pkg.sv
hdl/rsrs_dp.sv
hdl/rsrs_topk.sv
hdl/rsrs_ctrl.sv
hdl/region_size_rank_select_top.sv
tb/region_rank_checker.sv
tb/tb_region_size_rank_select_top.sv
